FILE: hdl/ast_pkg.sv
`timescale 1ns / 1ps
// shared constants and control types for the ordered set table
// no dependencies
package ast_pkg;

  // table depth default and fixed field widths
  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int FLD_W     = 5;
  localparam logic [FLD_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried in the input tuser
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic load_match;  // compare stored entry with the operand
    logic shift_match; // move match bits one cell toward the head
    logic ins_en;      // write operand into the cell at the count
    logic del_en;      // cells at or after the position take the neighbor entry
  } cell_ctl_t;

endpackage

FILE: hdl/array_set_table_unit.sv
`timescale 1ns / 1ps
// ordered set table top level: stream ports, capacity register, sequencer
// depends on ast_pkg and ast_chain
//
// Usage: an input transfer carries an operation in in_tuser and a signed
// 32-bit value in in_tdata. Each item gives exactly one result transfer with
// the position of the value before the operation, a found flag, the count
// after the operation and a status code. The block must be idle when the user
// writes the capacity register via cfg_valid/cfg_ready/cfg_data (unenforced).
// Timing: after the accept, the MATCH state loads the compare into every
// cell, then the match bits shift one cell per cycle toward cell zero until
// the hit or the end of the live entries. The result is then registered
// with the position where the scan stopped (position = count when absent).
// A new item can be taken the cycle after; in_tready is high only in IDLE,
// so no item is taken while the previous one is still being scanned.
// Reset: the count clears to zero and the capacity returns to 16; entries
// are not cleared, no clearing pass is needed.
// Stall: the result waits in the output register while out_tready is low;
// the next item is still accepted and scanned, and is held at its final
// scan step until the output register frees up.
module array_set_table_unit #(
  parameter int DEPTH = ast_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ast_pkg::FLD_W-1:0]   cfg_data,   // capacity_limit
  // operations in
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ast_pkg::VAL_W-1:0]   in_tdata,   // value[31:0]
  input  logic [1:0]                  in_tuser,   // mode[1:0]
  // results out
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // position[4:0], found[5],
                                                  // count_after[10:6], zero pad
  output logic [1:0]                  out_tuser   // status[1:0]
);
  import ast_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > FLD_W) ? CNT_W : FLD_W;

  typedef enum logic [1:0] {IDLE, MATCH, SCAN} state_t;

  state_t           state_r;
  logic [1:0]       mode_r;
  logic [VAL_W-1:0] value_r;
  logic [CNT_W-1:0] pos_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [FLD_W-1:0] cap_r;
  logic             out_valid_r;
  logic [FLD_W-1:0] out_pos_r;
  logic             out_found_r;
  logic [FLD_W-1:0] out_cnt_r;
  logic [1:0]       out_status_r;
  logic [1:0]       status_nxt;

  cell_ctl_t ctl;
  logic      head_match;
  logic      scan_end;
  logic      hit;
  logic      full;
  logic      out_free;
  logic      fire;

  // capacity register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  // scan decisions
  assign in_tready = (state_r == IDLE);
  assign scan_end  = (pos_r == count_r) || head_match;
  assign hit       = (pos_r != count_r);
  assign full      = (CMP_W'(count_r) >= CMP_W'(cap_r)) || (count_r == CNT_W'(DEPTH));
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = (state_r == SCAN) && scan_end && out_free;

  // commands to the cell row
  always_comb begin
    ctl.load_match  = (state_r == MATCH);
    ctl.shift_match = (state_r == SCAN) && !scan_end;
    ctl.ins_en      = fire && (mode_r == MODE_INSERT) && !hit && !full;
    ctl.del_en      = fire && (mode_r == MODE_DELETE) && hit;
  end

  // status and next count
  always_comb begin
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    priority if (mode_r == MODE_INSERT) begin
      if (hit) begin
        status_nxt = ST_DUP;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (mode_r == MODE_DELETE) begin
      if (!hit) begin
        status_nxt = ST_ABSENT;
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end else begin
      status_nxt = ST_DONE;
    end
  end

  // sequencer with registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_tvalid) begin
            mode_r  <= in_tuser;
            value_r <= in_tdata;
            pos_r   <= '0;
            state_r <= MATCH;
          end
        end
        MATCH: begin
          state_r <= SCAN;
        end
        SCAN: begin
          if (!scan_end) begin
            pos_r <= pos_r + CNT_W'(1);
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_pos_r    <= FLD_W'(pos_r);
            out_found_r  <= hit;
            out_cnt_r    <= FLD_W'(count_nxt);
            out_status_r <= status_nxt;
            count_r      <= count_nxt;
            state_r      <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  ast_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .pos        (pos_r),
    .count      (count_r),
    .value      (value_r),
    .head_match (head_match)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_found_r, out_pos_r};
  assign out_tuser  = out_status_r;

  // checks on the sequencer
  a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == MATCH))
    else $error("accepted item did not start a compare");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN) |-> (pos_r <= count_r))
    else $error("scan ran past the live entries");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_valid_r && (state_r == IDLE)))
    else $error("finished scan gave no result");

endmodule

FILE: hdl/ast_cell.sv
`timescale 1ns / 1ps
// one table cell: a stored entry and a match bit that shifts toward the head
// depends on ast_pkg
module ast_cell #(
  parameter int IDX     = 0,
  parameter int CNT_W   = 5,
  parameter bit IS_LAST = 1'b0
) (
  input  logic                       clk,
  input  ast_pkg::cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]           pos,
  input  logic [CNT_W-1:0]           count,
  input  logic [ast_pkg::VAL_W-1:0]  value,
  input  logic [ast_pkg::VAL_W-1:0]  next_entry,
  input  logic                       next_match,
  output logic [ast_pkg::VAL_W-1:0]  entry,
  output logic                       match
);
  import ast_pkg::*;

  logic [VAL_W-1:0] entry_r;
  logic             match_r;
  logic             at_count;
  logic             at_or_after;

  assign at_count    = (count == CNT_W'(IDX));
  assign at_or_after = (CNT_W'(IDX) >= pos);

  // stored entry: append at the count, compact on delete
  always_ff @(posedge clk) begin
    if (ctl.ins_en && at_count) begin
      entry_r <= value;
    end else if (ctl.del_en && at_or_after && !IS_LAST) begin
      entry_r <= next_entry;
    end
  end

  // match bit: load on compare, then hand toward cell zero
  always_ff @(posedge clk) begin
    if (ctl.load_match) begin
      match_r <= (entry_r == value);
    end else if (ctl.shift_match) begin
      match_r <= next_match;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

FILE: hdl/ast_chain.sv
`timescale 1ns / 1ps
// row of table cells linked to their upper neighbor
// depends on ast_pkg and ast_cell
module ast_chain #(
  parameter int DEPTH = ast_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  ast_pkg::cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]           pos,
  input  logic [CNT_W-1:0]           count,
  input  logic [ast_pkg::VAL_W-1:0]  value,
  output logic                       head_match
);
  import ast_pkg::*;

  logic [VAL_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0] match;

  // each cell takes entry and match bit from the cell above it
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] nxt_entry;
    logic             nxt_match;
    if (i == DEPTH - 1) begin : g_top
      assign nxt_entry = '0;
      assign nxt_match = 1'b0;
    end else begin : g_mid
      assign nxt_entry = entry[i+1];
      assign nxt_match = match[i+1];
    end
    ast_cell #(
      .IDX     (i),
      .CNT_W   (CNT_W),
      .IS_LAST (i == DEPTH - 1)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos),
      .count      (count),
      .value      (value),
      .next_entry (nxt_entry),
      .next_match (nxt_match),
      .entry      (entry[i]),
      .match      (match[i])
    );
  end

  assign head_match = match[0];

endmodule
